### rtl/prmd_pkg.sv
// prmd_pkg: types and constants for the packed rotation matrix decoder.
// No dependencies; imported by packed_rotation_matrix_decode, its checkers and tb_top.
package prmd_pkg;

  // Fixed-point 1.0 in signed 4.12
  localparam logic signed [15:0] ONE_FX = 16'sd4096;
  localparam logic signed [15:0] FX_MIN = -16'sd32768;
  localparam logic signed [15:0] FX_MAX = 16'sd32767;
  localparam logic [3:0]         PIVOT_MAX = 4'd8;

  // Width of a packed row element in five-word form
  localparam int unsigned ELEM_W = 13;
  localparam int unsigned PROD_W = 2 * ELEM_W;

  // Companion entries for each pivot position: A, B, +-B, +-A
  typedef logic [3:0] idx_t;
  localparam idx_t COMP_TAB [0:8][0:3] = '{
    '{4'd4, 4'd5, 4'd7, 4'd8}, '{4'd3, 4'd5, 4'd6, 4'd8}, '{4'd3, 4'd4, 4'd6, 4'd7},
    '{4'd1, 4'd2, 4'd7, 4'd8}, '{4'd0, 4'd2, 4'd6, 4'd8}, '{4'd0, 4'd1, 4'd6, 4'd7},
    '{4'd1, 4'd2, 4'd4, 4'd5}, '{4'd0, 4'd2, 4'd3, 4'd5}, '{4'd0, 4'd1, 4'd3, 4'd4}
  };

  // Input transaction
  typedef struct packed {
    logic        pivot_form;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
    logic [15:0] word4;
  } prmd_in_t;

  // Result transaction
  typedef struct packed {
    logic signed [15:0] e00;
    logic signed [15:0] e01;
    logic signed [15:0] e02;
    logic signed [15:0] e10;
    logic signed [15:0] e11;
    logic signed [15:0] e12;
    logic signed [15:0] e20;
    logic signed [15:0] e21;
    logic signed [15:0] e22;
    logic               bad_pivot;
  } prmd_out_t;

endpackage

### rtl/packed_rotation_matrix_decode.sv
// packed_rotation_matrix_decode: unpacks a compressed 3x3 rotation matrix.
// Depends on prmd_pkg (transaction types, companion table, constants).
//
//  channel  | handshake            | payload     | direction
//  ---------+----------------------+-------------+----------
//  command  | start / busy         | item        | in
//  result   | done (one-cycle)     | result      | out
//
// Three-stage pipeline: input register, decode + six 13x13 products, result
// register; done is registered alongside the result. One transaction is
// accepted every cycle, so busy stays low.
// Synchronous reset clears the stage valid flags and done only; payload is unreset.
// The receiver cannot stall; done marks each result for a single cycle.
module packed_rotation_matrix_decode
  import prmd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  prmd_in_t  item,
  output logic      done,
  output prmd_out_t result
);

  // Stage valid flags
  logic v0, v1;

  // Stage 0: input register
  prmd_in_t s0;

  // Stage 1 registers
  logic                      form1;
  logic                      bad1;
  logic signed [15:0]        piv1 [9];
  logic signed [ELEM_W-1:0]  row1 [6];
  logic signed [PROD_W-1:0]  prod1 [6];

  // Stage 1 combinational decode
  logic signed [15:0]        piv_m [9];
  logic                      bad_c;
  logic signed [ELEM_W-1:0]  row_c [6];
  logic signed [PROD_W-1:0]  prod_c [6];

  // Stage 2 combinational cross terms
  logic signed [PROD_W:0]    diff [3];
  logic signed [15:0]        cterm [3];
  prmd_out_t                 result_next;

  assign busy = 1'b0;

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= start && !busy;
      v1   <= v0;
      done <= v1;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s0 <= item;
    end
  end

  // Pivot form decode
  always_comb begin
    logic [3:0]         pv;
    logic signed [15:0] a, b, na, nb, c_b, c_a;
    pv    = s0.word0[3:0];
    a     = $signed(s0.word1);
    b     = $signed(s0.word2);
    na    = (a == FX_MIN) ? FX_MAX : -a;
    nb    = (b == FX_MIN) ? FX_MAX : -b;
    c_b   = s0.word0[5] ? nb : b;
    c_a   = s0.word0[6] ? na : a;
    bad_c = (pv > PIVOT_MAX);
    for (int j = 0; j < 9; j++) begin
      piv_m[j] = '0;
      if (!bad_c) begin
        if (pv == 4'(j)) begin
          piv_m[j] = s0.word0[4] ? -ONE_FX : ONE_FX;
        end else if (COMP_TAB[pv][0] == 4'(j)) begin
          piv_m[j] = a;
        end else if (COMP_TAB[pv][1] == 4'(j)) begin
          piv_m[j] = b;
        end else if (COMP_TAB[pv][2] == 4'(j)) begin
          piv_m[j] = c_b;
        end else if (COMP_TAB[pv][3] == 4'(j)) begin
          piv_m[j] = c_a;
        end
      end
    end
  end

  // Five-word unpack and cross-product terms
  always_comb begin
    row_c[0] = $signed(s0.word0[15:3]);
    row_c[1] = $signed(s0.word1[15:3]);
    row_c[2] = $signed(s0.word2[15:3]);
    row_c[3] = $signed(s0.word3[15:3]);
    row_c[4] = $signed(s0.word4[15:3]);
    // sixth element gathered from remnants; top two bits of word4's remnant drop
    row_c[5] = $signed({s0.word4[0], s0.word0[2:0], s0.word1[2:0],
                        s0.word2[2:0], s0.word3[2:0]});
    prod_c[0] = row_c[1] * row_c[5];
    prod_c[1] = row_c[2] * row_c[4];
    prod_c[2] = row_c[2] * row_c[3];
    prod_c[3] = row_c[0] * row_c[5];
    prod_c[4] = row_c[0] * row_c[4];
    prod_c[5] = row_c[1] * row_c[3];
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (v0) begin
      form1 <= s0.pivot_form;
      bad1  <= bad_c;
      piv1  <= piv_m;
      row1  <= row_c;
      prod1 <= prod_c;
    end
  end

  // Cross terms: exact difference, arithmetic shift (floor)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]  = (PROD_W+1)'(prod1[2*k]) - (PROD_W+1)'(prod1[2*k+1]);
      cterm[k] = 16'(diff[k] >>> 12);
    end
  end

  // Result selection
  always_comb begin
    if (form1) begin
      result_next.e00       = piv1[0];
      result_next.e01       = piv1[1];
      result_next.e02       = piv1[2];
      result_next.e10       = piv1[3];
      result_next.e11       = piv1[4];
      result_next.e12       = piv1[5];
      result_next.e20       = piv1[6];
      result_next.e21       = piv1[7];
      result_next.e22       = piv1[8];
      result_next.bad_pivot = bad1;
    end else begin
      result_next.e00       = 16'(row1[0]);
      result_next.e01       = 16'(row1[1]);
      result_next.e02       = 16'(row1[2]);
      result_next.e10       = 16'(row1[3]);
      result_next.e11       = 16'(row1[4]);
      result_next.e12       = 16'(row1[5]);
      result_next.e20       = cterm[0];
      result_next.e21       = cterm[1];
      result_next.e22       = cterm[2];
      result_next.bad_pivot = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (v1) begin
      result <= result_next;
    end
  end

endmodule

### rtl/prmd_checker.sv
// prmd_props: port-level assertions for packed_rotation_matrix_decode.
// Depends on prmd_pkg; bound to packed_rotation_matrix_decode at the end of this file.
module prmd_props
  import prmd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input prmd_in_t  item,
  input logic      done,
  input prmd_out_t result
);

  // Every accepted transaction yields a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result missing three cycles after accept");

  // No result without a matching accept
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without accepted transaction");

  // Bad pivot gives an all-zero matrix
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.bad_pivot) |->
      (result.e00 == 0 && result.e01 == 0 && result.e02 == 0 &&
       result.e10 == 0 && result.e11 == 0 && result.e12 == 0 &&
       result.e20 == 0 && result.e21 == 0 && result.e22 == 0))
    else $error("bad pivot with nonzero entries");

  // Bad pivot only flagged for pivot-form items with index above eight
  a_bad_src: assert property (@(posedge clk) disable iff (rst)
    (done && result.bad_pivot) |->
      ($past(item.pivot_form, 3) && ($past(item.word0[3:0], 3) > PIVOT_MAX)))
    else $error("bad pivot flag without a bad pivot index");

endmodule

bind packed_rotation_matrix_decode prmd_props u_prmd_props (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

### verif/prmd_checker.sv
// prmd_checker: scoreboard for packed_rotation_matrix_decode, plus the small
// testbench package shared with tb_top. Depends on prmd_pkg for the payload types.
package prmd_tb_pkg;
  // Encoding selector carried in the pivot_form field
  typedef enum logic {
    FORM_FIVE_WORD = 1'b0,
    FORM_PIVOT     = 1'b1
  } form_e;
endpackage

module prmd_checker
  import prmd_pkg::*;
  import prmd_tb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  prmd_in_t  item,
  input  logic      done,
  input  prmd_out_t result,
  output int        n_fail,
  output int        n_pending,
  output int        n_checked,
  output int        n_pivot,
  output int        n_bad_pivot
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0]  TOP_PIVOT = 4'd8;
  localparam logic [15:0] POS_ONE   = 16'h1000;
  localparam logic [15:0] NEG_ONE   = 16'hF000;
  localparam logic [15:0] MOST_NEG  = 16'h8000;
  localparam logic [15:0] MOST_POS  = 16'h7FFF;

  // Entries taking A, B, +-B, +-A for each pivot position
  localparam logic [0:8][0:3][3:0] COMPANION = {
    4'd4, 4'd5, 4'd7, 4'd8,   4'd3, 4'd5, 4'd6, 4'd8,   4'd3, 4'd4, 4'd6, 4'd7,
    4'd1, 4'd2, 4'd7, 4'd8,   4'd0, 4'd2, 4'd6, 4'd8,   4'd0, 4'd1, 4'd6, 4'd7,
    4'd1, 4'd2, 4'd4, 4'd5,   4'd0, 4'd2, 4'd3, 4'd5,   4'd0, 4'd1, 4'd3, 4'd4
  };

  prmd_out_t matrix_q[$];

  initial begin
    n_fail      = 0;
    n_pending   = 0;
    n_checked   = 0;
    n_pivot     = 0;
    n_bad_pivot = 0;
  end

  // Negation that clips the most negative value
  function automatic logic [15:0] negate_clip(input logic [15:0] v);
    if (v == MOST_NEG) return MOST_POS;
    return -v;
  endfunction

  // One cross-product term, floored by the arithmetic shift
  function automatic logic [15:0] cross_entry(input int x, input int y, input int z,
                                              input int w);
    int full;
    full = x * y - z * w;
    return 16'(full >>> 12);
  endfunction

  // Expected matrix for one record
  function automatic prmd_out_t decode_matrix(input prmd_in_t x);
    logic [15:0] m [9];
    logic [3:0]  pv;
    logic [14:0] gather;
    int          a0, a1, a2, b0, b1, b2;
    prmd_out_t   r;
    foreach (m[i]) m[i] = '0;
    r.bad_pivot = 1'b0;
    if (x.pivot_form == FORM_PIVOT) begin
      pv = x.word0[3:0];
      if (pv > TOP_PIVOT) begin
        r.bad_pivot = 1'b1;
      end else begin
        m[pv]              = x.word0[4] ? NEG_ONE : POS_ONE;
        m[COMPANION[pv][0]] = x.word1;
        m[COMPANION[pv][1]] = x.word2;
        m[COMPANION[pv][2]] = x.word0[5] ? negate_clip(x.word2) : x.word2;
        m[COMPANION[pv][3]] = x.word0[6] ? negate_clip(x.word1) : x.word1;
      end
    end else begin
      a0 = $signed(x.word0[15:3]);
      a1 = $signed(x.word1[15:3]);
      a2 = $signed(x.word2[15:3]);
      b0 = $signed(x.word3[15:3]);
      b1 = $signed(x.word4[15:3]);
      // sixth element from the remnants; top two bits of word4's remnant drop out
      gather = {x.word4[2:0], x.word0[2:0], x.word1[2:0], x.word2[2:0], x.word3[2:0]};
      b2 = $signed(gather[12:0]);
      m[0] = 16'(a0);
      m[1] = 16'(a1);
      m[2] = 16'(a2);
      m[3] = 16'(b0);
      m[4] = 16'(b1);
      m[5] = 16'(b2);
      m[6] = cross_entry(a1, b2, a2, b1);
      m[7] = cross_entry(a2, b0, a0, b2);
      m[8] = cross_entry(a0, b1, a1, b0);
    end
    r.e00 = m[0]; r.e01 = m[1]; r.e02 = m[2];
    r.e10 = m[3]; r.e11 = m[4]; r.e12 = m[5];
    r.e20 = m[6]; r.e21 = m[7]; r.e22 = m[8];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    n_fail++;
  endtask

  // Field-by-field comparison against the oldest expected matrix
  task automatic compare_matrix(input prmd_out_t got, input prmd_out_t want);
    logic [144:0] gv, wv;
    string        names [9];
    names = '{"e00", "e01", "e02", "e10", "e11", "e12", "e20", "e21", "e22"};
    gv = got;
    wv = want;
    for (int k = 0; k < 9; k++) begin
      if (gv[144 - 16 * k -: 16] !== wv[144 - 16 * k -: 16])
        report_mismatch($sformatf("%s got %h expected %h", names[k],
                                  gv[144 - 16 * k -: 16], wv[144 - 16 * k -: 16]));
    end
    if (got.bad_pivot !== want.bad_pivot)
      report_mismatch($sformatf("bad_pivot got %b expected %b", got.bad_pivot,
                                want.bad_pivot));
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done !== 1'b0) begin
        if (matrix_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          compare_matrix(result, matrix_q.pop_front());
          n_checked++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        matrix_q.push_back(decode_matrix(item));
        if (item.pivot_form == FORM_PIVOT) begin
          n_pivot++;
          if (item.word0[3:0] > TOP_PIVOT) n_bad_pivot++;
        end
      end
      n_pending <= matrix_q.size();
    end
  end

endmodule

### verif/tb_top.sv
// tb_top: stimulus and verdict for packed_rotation_matrix_decode.
// Depends on prmd_pkg, prmd_tb_pkg and prmd_checker (verif/prmd_checker.sv).
module tb_top
  import prmd_pkg::*;
  import prmd_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 388;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  prmd_in_t  item;
  logic      done;
  prmd_out_t result;
  int        n_fail, n_pending, n_checked, n_pivot, n_bad_pivot;

  packed_rotation_matrix_decode u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  prmd_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .n_fail      (n_fail),
    .n_pending   (n_pending),
    .n_checked   (n_checked),
    .n_pivot     (n_pivot),
    .n_bad_pivot (n_bad_pivot)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #200000;
    $display("packed_rotation_matrix_decode test failed");
    $finish;
  end

  // Random word, leaning on the extremes now and then
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic prmd_in_t rand_record(input form_e form);
    prmd_in_t x;
    x.pivot_form = form;
    x.word0 = rand_word();
    x.word1 = rand_word();
    x.word2 = rand_word();
    x.word3 = rand_word();
    x.word4 = rand_word();
    // mostly legal pivots so the companion table gets exercised
    if (form == FORM_PIVOT && $urandom_range(0, 4) != 0)
      x.word0[3:0] = 4'($urandom_range(0, 8));
    return x;
  endfunction

  function automatic prmd_in_t make_record(input form_e form, input logic [15:0] w0,
                                           input logic [15:0] w1, input logic [15:0] w2,
                                           input logic [15:0] w3, input logic [15:0] w4);
    prmd_in_t x;
    x.pivot_form = form;
    x.word0 = w0;
    x.word1 = w1;
    x.word2 = w2;
    x.word3 = w3;
    x.word4 = w4;
    return x;
  endfunction

  // Present one record from a falling edge, optionally after an idle gap
  task automatic send_record(input prmd_in_t x, input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      item  <= rand_record(form_e'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start <= 1'b1;
    item  <= x;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Hold the command channel quiet until every matrix has come back
  task automatic drain();
    start <= 1'b0;
    while (n_pending != 0) @(negedge clk);
  endtask

  initial begin
    int idle_pct [4];
    int drain_wait;
    // sender idle rates per phase; the result side cannot stall, so its phases
    // reduce to the sender's share
    idle_pct = '{0, 53, 0, 8};
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every pivot position with sign-bit mixes and clipping operands
    for (int p = 0; p <= 8; p++) begin
      send_record(make_record(FORM_PIVOT,
                              {(p % 2 == 1) ? 9'h1FF : 9'h000, 3'(p), 4'(p)},
                              (p % 2 == 0) ? 16'h8000 : 16'h7FFF,
                              (p % 3 == 0) ? 16'h8000 : 16'h8001,
                              16'hFFFF, 16'hFFFF), 0);
    end
    send_record(make_record(FORM_PIVOT, 16'h0074, 16'h8000, 16'h8000, 16'h0000,
                            16'h0000), 0);
    send_record(make_record(FORM_PIVOT, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
                            16'h0000), 0);
    // bad pivot indices, lowest and highest
    send_record(make_record(FORM_PIVOT, 16'h0079, 16'h1234, 16'h4321, 16'h0000,
                            16'h0000), 0);
    send_record(make_record(FORM_PIVOT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF), 0);
    // Five-word extremes and remnant gathering
    send_record(make_record(FORM_FIVE_WORD, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            16'h0000), 0);
    send_record(make_record(FORM_FIVE_WORD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF), 0);
    send_record(make_record(FORM_FIVE_WORD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h7FFF), 0);
    send_record(make_record(FORM_FIVE_WORD, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8001), 0);
    send_record(make_record(FORM_FIVE_WORD, 16'h7FF8, 16'h8000, 16'h7FF8, 16'h8000,
                            16'h7FF9), 0);
    send_record(make_record(FORM_FIVE_WORD, 16'h8000, 16'h7FF8, 16'h8000, 16'h7FF8,
                            16'h8006), 0);
    send_record(make_record(FORM_FIVE_WORD, 16'h0001, 16'h0002, 16'h0004, 16'h0001,
                            16'h0006), 0);
    // small negative products to exercise the floor on the shift
    send_record(make_record(FORM_FIVE_WORD, 16'h0008, 16'hFFF8, 16'h0010, 16'h0018,
                            16'hFFF0), 0);
    send_record(make_record(FORM_FIVE_WORD, 16'h1F05, 16'hE0A3, 16'h3C1E, 16'hC2F7,
                            16'h5502), 0);
    drain();

    // Random phases, each ending with the sender waiting for a full drain
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_record(rand_record(form_e'($urandom_range(0, 1))), idle_pct[ph]);
      drain();
    end

    // let any stray result show up
    drain_wait = 0;
    while (drain_wait < 8) begin
      @(negedge clk);
      drain_wait++;
    end
    $display("Checked %0d matrices: %0d pivot form (%0d bad index), %0d five-word form",
             n_checked, n_pivot, n_bad_pivot, n_checked - n_pivot);
    $display("Pacing covered back-to-back, sparse and lightly gapped command streams");
    if (n_fail == 0)
      $display("packed_rotation_matrix_decode test passed");
    else
      $display("packed_rotation_matrix_decode test failed");
    $finish;
  end

endmodule

### packed_rotation_matrix_decode.f
rtl/prmd_pkg.sv
rtl/packed_rotation_matrix_decode.sv
rtl/prmd_checker.sv
verif/prmd_checker.sv
verif/tb_top.sv
